// File: src/s2d_pkg.sv
// Shared constants and types for the signed binary to decimal ASCII converter.
`timescale 1ns / 1ps

package s2d_pkg;

  localparam int unsigned ValueW  = 64;
  localparam int unsigned Digits  = 20;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned CharW   = 7;
  localparam int unsigned BitCntW = $clog2(ValueW);
  localparam int unsigned RemW    = $clog2(Digits + 1);

  localparam logic [CharW-1:0] CharZero  = 7'h30;
  localparam logic [CharW-1:0] CharMinus = 7'h2D;

  // Control shared by every digit cell of the chain
  typedef struct packed {
    logic clear;   // zero the digit
    logic dabble;  // add-3 correction then shift one binary bit in
    logic shift;   // move digits one place up the chain
  } cell_ctrl_t;

endpackage

// File: src/s2d_bcd_cell.sv
// One BCD digit cell of the double-dabble chain.
`timescale 1ns / 1ps

module s2d_bcd_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  s2d_pkg::cell_ctrl_t             ctrl_i,
  input  logic                            bit_i,
  input  logic [s2d_pkg::DigitW-1:0]      dig_i,
  output logic                            bit_o,
  output logic [s2d_pkg::DigitW-1:0]      dig_o
);

  logic [s2d_pkg::DigitW-1:0] dig_q, dig_d;
  logic [s2d_pkg::DigitW-1:0] adj;

  // add 3 when the digit would overflow past 9 on doubling
  assign adj   = (dig_q >= 4'd5) ? (dig_q + 4'd3) : dig_q;
  assign bit_o = adj[s2d_pkg::DigitW-1];
  assign dig_o = dig_q;

  always_comb begin
    dig_d = dig_q;
    if (ctrl_i.clear) begin
      dig_d = '0;
    end else if (ctrl_i.dabble) begin
      dig_d = {adj[s2d_pkg::DigitW-2:0], bit_i};
    end else if (ctrl_i.shift) begin
      dig_d = dig_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_q <= '0;
    end else begin
      dig_q <= dig_d;
    end
  end

endmodule

// File: src/signed_int_to_decimal_ascii.sv
// Top level: signed 64-bit integer to decimal ASCII text, one number per request.
// Sequence: after the accept edge the magnitude is double-dabbled through the digit
//   chain one input bit per cycle, then leading zeros are dropped in the skip state
//   before the first character is registered; fewer zeros for longer numbers.
// Throughput: one number at a time; sign and digits go out one per cycle while the
//   output is not stalled, and the next request is taken the cycle after the last.
// Reset: asynchronous active low; returns to idle with no character pending.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [s2d_pkg::ValueW-1:0] signed_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [s2d_pkg::CharW-1:0]        text_char_o,
  output logic                             last_char_o
);

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StSkip,
    StSign,
    StDigs
  } state_e;

  localparam int unsigned Top = s2d_pkg::Digits - 1;

  state_e                          state_q;
  logic [s2d_pkg::ValueW-1:0]      mag_q;
  logic                            neg_q;
  logic [s2d_pkg::BitCntW-1:0]     bit_cnt_q;
  logic [s2d_pkg::RemW-1:0]        rem_q;
  logic                            out_valid_q;
  logic [s2d_pkg::CharW-1:0]       out_char_q;
  logic                            out_last_q;

  s2d_pkg::cell_ctrl_t             ctrl;
  logic [s2d_pkg::Digits:0]        chain_bit;
  logic [s2d_pkg::DigitW-1:0]      chain_dig [s2d_pkg::Digits+1];
  logic                            in_fire;
  logic                            out_free;
  logic                            out_load;
  logic [s2d_pkg::DigitW-1:0]      top_dig;

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_load    = ((state_q == StSign) || (state_q == StDigs)) && out_free;
  assign out_valid_o = out_valid_q;
  assign text_char_o = out_char_q;
  assign last_char_o = out_last_q;
  assign top_dig     = chain_dig[Top+1];

  // Chain control from the sequencer
  always_comb begin
    ctrl        = '0;
    ctrl.clear  = in_fire;
    ctrl.dabble = (state_q == StConv);
    ctrl.shift  = ((state_q == StSkip) && (top_dig == '0) && (rem_q > 1)) ||
                  ((state_q == StDigs) && out_free);
  end

  // Digit chain: cell 0 is the least significant digit
  assign chain_bit[0] = mag_q[s2d_pkg::ValueW-1];
  assign chain_dig[0] = '0;

  for (genvar g = 0; g < s2d_pkg::Digits; g++) begin : g_cell
    s2d_bcd_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .bit_i  (chain_bit[g]),
      .dig_i  (chain_dig[g]),
      .bit_o  (chain_bit[g+1]),
      .dig_o  (chain_dig[g+1])
    );
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      bit_cnt_q   <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            neg_q     <= signed_value_i[s2d_pkg::ValueW-1];
            mag_q     <= signed_value_i[s2d_pkg::ValueW-1] ?
                         (~signed_value_i + 64'd1) : signed_value_i;
            bit_cnt_q <= '0;
            rem_q     <= s2d_pkg::RemW'(s2d_pkg::Digits);
            state_q   <= StConv;
          end
        end
        StConv: begin
          mag_q     <= {mag_q[s2d_pkg::ValueW-2:0], 1'b0};
          bit_cnt_q <= bit_cnt_q + 1'b1;
          if (bit_cnt_q == s2d_pkg::BitCntW'(s2d_pkg::ValueW - 1)) begin
            state_q <= StSkip;
          end
        end
        StSkip: begin
          // drop leading zeros, keep at least one digit
          if ((top_dig == '0) && (rem_q > 1)) begin
            rem_q <= rem_q - 1'b1;
          end else begin
            state_q <= neg_q ? StSign : StDigs;
          end
        end
        StSign: begin
          if (out_free) begin
            out_char_q  <= s2d_pkg::CharMinus;
            out_last_q  <= 1'b0;
            state_q     <= StDigs;
          end
        end
        StDigs: begin
          if (out_free) begin
            out_char_q  <= s2d_pkg::CharZero + s2d_pkg::CharW'(top_dig);
            out_last_q  <= (rem_q == 1);
            rem_q       <= rem_q - 1'b1;
            if (rem_q == 1) begin
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Checks
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (text_char_o == s2d_pkg::CharMinus)) |-> !last_char_o)
    else $error("minus sign flagged as last character");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (text_char_o != s2d_pkg::CharMinus)) |->
      ((text_char_o >= s2d_pkg::CharZero) && (text_char_o <= s2d_pkg::CharZero + 7'd9)))
    else $error("character is neither minus nor a decimal digit");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != StIdle) && (state_q != StConv)) |->
      ((rem_q != 0) && (rem_q <= s2d_pkg::RemW'(s2d_pkg::Digits))))
    else $error("digit count out of range");

  a_conv_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StConv) && (bit_cnt_q == s2d_pkg::BitCntW'(s2d_pkg::ValueW - 1)))
      |=> (state_q == StSkip))
    else $error("conversion did not end after the last bit");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> ((state_q == StConv) && (bit_cnt_q == '0)))
    else $error("accepted request did not start conversion");

endmodule

// File: sim/signed_int_to_decimal_ascii_tb.sv
// Testbench for the signed 64-bit integer to decimal ASCII converter.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;

  localparam int unsigned CycleLimit = 200000;

  // One expected character of the decimal text
  typedef struct packed {
    logic [s2d_pkg::CharW-1:0] ch;
    logic                      last;
  } text_beat_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              in_valid_i = 1'b0;
  logic                              in_ready_o;
  logic signed [s2d_pkg::ValueW-1:0] signed_value_i = '0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic [s2d_pkg::CharW-1:0]         text_char_o;
  logic                              last_char_o;

  logic signed [s2d_pkg::ValueW-1:0] value_backlog[$];
  text_beat_t                        expected_text[$];
  logic                              in_fire = 1'b0;
  int                                sent_cnt = 0;
  int                                fail_cnt = 0;
  int unsigned                       cycle_cnt = 0;

  // Both sides run without idling over a middle stretch of requests
  wire steady = (sent_cnt >= 45) && (sent_cnt < 80);

  signed_int_to_decimal_ascii u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .signed_value_i (signed_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .text_char_o    (text_char_o),
    .last_char_o    (last_char_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Expected text of one number: optional minus, then digits, no leading zeros
  function automatic void predict_text(input logic signed [s2d_pkg::ValueW-1:0] value);
    logic [s2d_pkg::ValueW-1:0] mag;
    logic [3:0]                 digs[s2d_pkg::Digits];
    int                         nd;
    text_beat_t                 beat;
    nd = 0;
    mag = value[s2d_pkg::ValueW-1] ? (~value + 1'b1) : value;
    do begin
      digs[nd] = 4'(mag % 10);
      mag = mag / 10;
      nd++;
    end while (mag != 0 && nd < s2d_pkg::Digits);
    if (value[s2d_pkg::ValueW-1]) begin
      beat.ch = s2d_pkg::CharMinus;
      beat.last = 1'b0;
      expected_text.push_back(beat);
    end
    for (int k = nd - 1; k >= 0; k--) begin
      beat.ch = s2d_pkg::CharZero + s2d_pkg::CharW'(digs[k]);
      beat.last = (k == 0);
      expected_text.push_back(beat);
    end
  endfunction

  // Prediction on accepted requests, checking of accepted characters
  always @(posedge clk_i) begin
    text_beat_t want;
    in_fire <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) predict_text(signed_value_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected character %h last %b", $time, text_char_o, last_char_o);
        fail_cnt++;
      end else begin
        want = expected_text.pop_front();
        if (text_char_o !== want.ch) begin
          $display("%0t: text_char expected %h actual %h", $time, want.ch, text_char_o);
          fail_cnt++;
        end
        if (last_char_o !== want.last) begin
          $display("%0t: last_char expected %b actual %b", $time, want.last, last_char_o);
          fail_cnt++;
        end
      end
    end
  end

  // Request driver and output back-pressure
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (value_backlog.size() != 0 && (steady || $urandom_range(99) >= 27)) begin
        signed_value_i <= value_backlog.pop_front();
        in_valid_i <= 1'b1;
        sent_cnt++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= steady || ($urandom_range(99) >= 27);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic signed [s2d_pkg::ValueW-1:0] r;
    logic [s2d_pkg::ValueW-1:0]        p;

    // Directed: zero, single digits, digit-count boundaries, both extremes
    value_backlog.push_back(64'sd0);
    value_backlog.push_back(64'sd1);
    value_backlog.push_back(-64'sd1);
    value_backlog.push_back(64'sd9);
    value_backlog.push_back(64'sd10);
    value_backlog.push_back(-64'sd10);
    value_backlog.push_back(64'sd99);
    value_backlog.push_back(64'sd100);
    value_backlog.push_back(64'sd12345);
    value_backlog.push_back(-64'sd987654321);
    value_backlog.push_back(64'sd999999999999999999);
    value_backlog.push_back(64'sd1000000000000000000);
    value_backlog.push_back(-64'sd1000000000000000000);
    value_backlog.push_back(64'h7FFF_FFFF_FFFF_FFFF);
    value_backlog.push_back(64'h8000_0000_0000_0000);
    value_backlog.push_back(64'h8000_0000_0000_0001);
    value_backlog.push_back(64'sd4294967296);
    value_backlog.push_back(64'h5555_5555_5555_5555);
    value_backlog.push_back(64'hAAAA_AAAA_AAAA_AAAA);

    // Random: full width, short magnitudes, and values around powers of ten
    repeat (101) begin
      r = {$urandom, $urandom};
      case ($urandom_range(3))
        0: r = r >>> $urandom_range(63);
        1: r = {1'b0, r[s2d_pkg::ValueW-2:0]} >> $urandom_range(63);
        2: begin
          p = 1;
          repeat ($urandom_range(18)) p = p * 10;
          r = p - $urandom_range(1);
        end
        default: ;
      endcase
      if ($urandom_range(3) == 0) r = -r;
      value_backlog.push_back(r);
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (value_backlog.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_text.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);

    if (expected_text.size() != 0) begin
      $display("%0t: %0d characters never arrived", $time, expected_text.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
